[rtl/core/wmsp_pkg.sv]
`timescale 1ns / 1ps
// wmsp_pkg: shared constants, register codes and the work item type of the
// window match / score peak detector. No dependencies.
package wmsp_pkg;

   localparam int MAX_QUERY_DEF = 16;   // default window depth
   localparam int QUERY_SLOTS   = 16;   // characters held by the two query registers
   localparam int CHAR_W        = 8;
   localparam int LEN_W         = 5;
   localparam int POS_W         = 32;
   localparam int SUM_W         = 32;
   localparam int SCORE_W       = 7;
   localparam int CFG_DATA_W    = 64;
   localparam int CFG_ADDR_W    = 5;
   localparam int QUEUE_DEPTH   = 2;
   localparam int MATCH_POINTS  = 3;    // +3 on a match, -3 on a miss

   // "CACCA" packed, first character in the low byte
   localparam logic [CFG_DATA_W-1:0] QUERY_LOW_RESET  = 64'd280301355331;
   localparam logic [CFG_DATA_W-1:0] QUERY_HIGH_RESET = 64'd0;
   localparam logic [LEN_W-1:0]      QUERY_LEN_RESET  = 5'd5;

   typedef enum logic [1:0] {
      REG_QUERY_LOW  = 2'd0,
      REG_QUERY_HIGH = 2'd1,
      REG_QUERY_LEN  = 2'd2
   } reg_index_type;

   // START: first full window, its score starts a new sum.
   // STEP:  any later window, score is accumulated and tested for a peak.
   typedef enum logic {
      KIND_START = 1'b0,
      KIND_STEP  = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type             kind;
      logic signed [SCORE_W-1:0] score;
      logic [POS_W-1:0]          position;
   } work_item_type;

endpackage

[rtl/core/wmsp_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the character stream and the peak results.
// Depends on nothing.
interface wmsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;

   modport source (output valid, output in_char, input ready);
   modport sink (input valid, input in_char, output ready);
endinterface

interface wmsp_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        peak_position;
   logic signed [31:0] peak_sum;
   logic signed [6:0]  peak_window_score;

   modport source (output valid, output peak_position, output peak_sum,
                   output peak_window_score, input ready);
   modport sink (input valid, input peak_position, input peak_sum,
                 input peak_window_score, output ready);
endinterface

[rtl/core/wmsp_front.sv]
`timescale 1ns / 1ps
// wmsp_front: takes characters, keeps the sliding window and fill count,
// scores each full window and hands work items to the queue. Uses wmsp_pkg.
module wmsp_front #(
   parameter int MAX_QUERY = wmsp_pkg::MAX_QUERY_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   wmsp_req_if.sink                                req,
   input  logic [wmsp_pkg::QUERY_SLOTS-1:0][7:0]   query_chars,
   input  logic [wmsp_pkg::LEN_W-1:0]              eff_len,
   output logic                                    push_valid,
   input  logic                                    push_ready,
   output wmsp_pkg::work_item_type                 push_item
);

   localparam int IDX_W = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
   localparam int CNT_W = $clog2(MAX_QUERY + 1);

   logic [MAX_QUERY-1:0][7:0]         win_ff, win_in;
   logic [wmsp_pkg::LEN_W-1:0]        fill_ff, fill_in;
   logic [wmsp_pkg::POS_W-1:0]        char_cnt_ff, char_cnt_in;
   logic                              stage_valid_ff, stage_valid_in;
   wmsp_pkg::item_kind_type           kind_ff, kind_in;
   logic [wmsp_pkg::POS_W-1:0]        position_ff, position_in;

   logic                              accept;
   logic [MAX_QUERY-1:0]              hits;
   logic [CNT_W-1:0]                  match_cnt;
   logic signed [7:0]                 score_wide;

   assign req.ready = !stage_valid_ff || push_ready;
   assign accept    = req.valid && req.ready;

   // next state for window, counters and the staged item
   always_comb begin
      win_in         = win_ff;
      fill_in        = fill_ff;
      char_cnt_in    = char_cnt_ff;
      kind_in        = kind_ff;
      position_in    = position_ff;
      stage_valid_in = stage_valid_ff && !push_ready;
      if (accept) begin
         win_in[0] = req.in_char;
         for (int k = 1; k < MAX_QUERY; k++) begin
            win_in[k] = win_ff[k-1];
         end
         char_cnt_in = char_cnt_ff + 1'b1;
         position_in = char_cnt_ff + 1'b1;   // one-based index of this character
         if (fill_ff < eff_len) begin
            fill_in        = fill_ff + 1'b1;
            kind_in        = wmsp_pkg::KIND_START;
            stage_valid_in = ((fill_ff + 1'b1) == eff_len);
         end else begin
            kind_in        = wmsp_pkg::KIND_STEP;
            stage_valid_in = 1'b1;
         end
      end
   end

   // query char i against window entry len-1-i (oldest first)
   always_comb begin
      logic [wmsp_pkg::LEN_W-1:0] idx;
      hits = '0;
      for (int i = 0; i < MAX_QUERY; i++) begin
         idx     = eff_len - wmsp_pkg::LEN_W'(i) - 1'b1;
         hits[i] = (wmsp_pkg::LEN_W'(i) < eff_len) &&
                   (win_ff[idx[IDX_W-1:0]] == query_chars[i]);
      end
   end

   assign match_cnt  = CNT_W'($countones(hits));
   // score = 3*hits - 3*(len-hits) = 6*hits - 3*len
   assign score_wide = $signed(8'(match_cnt) * 8'(2 * wmsp_pkg::MATCH_POINTS)
                               - 8'(eff_len) * 8'(wmsp_pkg::MATCH_POINTS));

   assign push_valid         = stage_valid_ff;
   assign push_item.kind     = kind_ff;
   assign push_item.score    = score_wide[wmsp_pkg::SCORE_W-1:0];
   assign push_item.position = position_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff         <= '0;
         fill_ff        <= '0;
         char_cnt_ff    <= '0;
         stage_valid_ff <= 1'b0;
         kind_ff        <= wmsp_pkg::KIND_START;
      end else begin
         win_ff         <= win_in;
         fill_ff        <= fill_in;
         char_cnt_ff    <= char_cnt_in;
         stage_valid_ff <= stage_valid_in;
         kind_ff        <= kind_in;
      end
      position_ff <= position_in;
   end

endmodule

[rtl/core/wmsp_queue.sv]
`timescale 1ns / 1ps
// wmsp_queue: small FIFO of scored work items between front and back.
// Uses wmsp_pkg.
module wmsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  wmsp_pkg::work_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output wmsp_pkg::work_item_type pop_item
);

   localparam int DEPTH = wmsp_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   wmsp_pkg::work_item_type mem [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/core/wmsp_back.sv]
`timescale 1ns / 1ps
// wmsp_back: running saturating sum, three-deep sum history, peak test and
// the registered result beat. Uses wmsp_pkg and wmsp_if.
module wmsp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  wmsp_pkg::work_item_type pop_item,
   wmsp_rsp_if.source              rsp
);

   localparam int SUM_W   = wmsp_pkg::SUM_W;
   localparam int SCORE_W = wmsp_pkg::SCORE_W;

   logic signed [SUM_W-1:0]   sum_cur_ff, sum_cur_in;
   logic signed [SUM_W-1:0]   sum_prev_ff, sum_prev_in;
   logic signed [SUM_W-1:0]   sum_bp_ff, sum_bp_in;
   logic [1:0]                hist_ff, hist_in;
   logic signed [SCORE_W-1:0] last_score_ff, last_score_in;
   logic                      out_valid_ff, out_valid_in;
   logic [wmsp_pkg::POS_W-1:0] out_pos_ff, out_pos_in;
   logic signed [SUM_W-1:0]   out_sum_ff, out_sum_in;
   logic signed [SCORE_W-1:0] out_score_ff, out_score_in;

   logic                      pop;
   logic signed [SUM_W:0]     sum_wide;
   logic signed [SUM_W-1:0]   sum_sat;

   assign pop_ready = !out_valid_ff || rsp.ready;
   assign pop       = pop_valid && pop_ready;

   assign sum_wide = (SUM_W+1)'(pop_item.score) + (SUM_W+1)'(sum_cur_ff);

   always_comb begin
      if (sum_wide > $signed((SUM_W+1)'({1'b0, {(SUM_W-1){1'b1}}}))) begin
         sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
      end else if (sum_wide < $signed((SUM_W+1)'({2'b11, {(SUM_W-1){1'b0}}}))) begin
         sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   always_comb begin
      sum_cur_in    = sum_cur_ff;
      sum_prev_in   = sum_prev_ff;
      sum_bp_in     = sum_bp_ff;
      hist_in       = hist_ff;
      last_score_in = last_score_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_pos_in    = out_pos_ff;
      out_sum_in    = out_sum_ff;
      out_score_in  = out_score_ff;
      if (pop) begin
         last_score_in = pop_item.score;
         unique case (pop_item.kind)
            wmsp_pkg::KIND_START: begin
               sum_cur_in  = SUM_W'(pop_item.score);
               sum_prev_in = '0;
               sum_bp_in   = '0;
               hist_in     = 2'd1;
            end
            wmsp_pkg::KIND_STEP: begin
               if (hist_ff == 2'd0) begin
                  // empty history: this score starts the sum on its own
                  sum_cur_in = SUM_W'(pop_item.score);
                  hist_in    = 2'd1;
               end else begin
                  sum_bp_in   = sum_prev_ff;
                  sum_prev_in = sum_cur_ff;
                  sum_cur_in  = sum_sat;
                  if (hist_ff != 2'd3) begin
                     hist_in = hist_ff + 1'b1;
                  end else if (sum_sat < sum_cur_ff && sum_prev_ff < sum_cur_ff) begin
                     // peak lies one window back
                     out_valid_in = 1'b1;
                     out_pos_in   = pop_item.position - 1'b1;
                     out_sum_in   = sum_cur_ff;
                     out_score_in = last_score_ff;
                     sum_prev_in  = '0;
                     sum_bp_in    = '0;
                     hist_in      = 2'd1;
                  end
               end
            end
            default: begin
               sum_cur_in = sum_cur_ff;
            end
         endcase
      end
   end

   assign rsp.valid             = out_valid_ff;
   assign rsp.peak_position     = out_pos_ff;
   assign rsp.peak_sum          = out_sum_ff;
   assign rsp.peak_window_score = out_score_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_cur_ff    <= '0;
         sum_prev_ff   <= '0;
         sum_bp_ff     <= '0;
         hist_ff       <= '0;
         last_score_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         sum_cur_ff    <= sum_cur_in;
         sum_prev_ff   <= sum_prev_in;
         sum_bp_ff     <= sum_bp_in;
         hist_ff       <= hist_in;
         last_score_ff <= last_score_in;
         out_valid_ff  <= out_valid_in;
      end
      out_pos_ff   <= out_pos_in;
      out_sum_ff   <= out_sum_in;
      out_score_ff <= out_score_in;
   end

endmodule

[rtl/core/window_match_score_peak_detect.sv]
`timescale 1ns / 1ps
// window_match_score_peak_detect: top level, query registers on the APB port,
// front scorer, work queue and sum/peak back end. Uses wmsp_pkg, wmsp_if.
// A character that completes a peak passes the front stage register, then the
// queue, then the result register before its result beat shows.
// Throughput: one character beat per cycle unless the front stage is held by a
// full queue; set by the combinational window compare in the front and the
// single running-sum add in the back.
// Reset (synchronous, active high) clears window, counters, sum history and
// all handshakes, and loads the query "CACCA" with length 5; no clearing pass.
module window_match_score_peak_detect #(
   parameter int MAX_QUERY = wmsp_pkg::MAX_QUERY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   wmsp_req_if.sink                            req,
   wmsp_rsp_if.source                          rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [wmsp_pkg::CFG_ADDR_W-1:0]     paddr,
   input  logic [wmsp_pkg::CFG_DATA_W-1:0]     pwdata,
   output logic [wmsp_pkg::CFG_DATA_W-1:0]     prdata,
   output logic                                pready
);

   // Query registers; register i sits at byte address 8*i.
   logic [wmsp_pkg::CFG_DATA_W-1:0] query_low_ff, query_low_in;
   logic [wmsp_pkg::CFG_DATA_W-1:0] query_high_ff, query_high_in;
   logic [wmsp_pkg::LEN_W-1:0]      query_len_ff, query_len_in;

   logic                            csr_write;
   wmsp_pkg::reg_index_type         csr_index;
   logic [wmsp_pkg::LEN_W-1:0]      eff_len;
   logic [wmsp_pkg::QUERY_SLOTS-1:0][7:0] query_chars;

   // queue hookup
   logic                            push_valid, push_ready;
   wmsp_pkg::work_item_type         push_item;
   logic                            pop_valid, pop_ready;
   wmsp_pkg::work_item_type         pop_item;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = wmsp_pkg::reg_index_type'(paddr[4:3]);

   always_comb begin
      query_low_in  = query_low_ff;
      query_high_in = query_high_ff;
      query_len_in  = query_len_ff;
      if (csr_write) begin
         unique case (csr_index)
            wmsp_pkg::REG_QUERY_LOW:  query_low_in  = pwdata;
            wmsp_pkg::REG_QUERY_HIGH: query_high_in = pwdata;
            wmsp_pkg::REG_QUERY_LEN:  query_len_in  = pwdata[wmsp_pkg::LEN_W-1:0];
            default:                  query_len_in  = query_len_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         wmsp_pkg::REG_QUERY_LOW:  prdata = query_low_ff;
         wmsp_pkg::REG_QUERY_HIGH: prdata = query_high_ff;
         wmsp_pkg::REG_QUERY_LEN:  prdata = wmsp_pkg::CFG_DATA_W'(query_len_ff);
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_low_ff  <= wmsp_pkg::QUERY_LOW_RESET;
         query_high_ff <= wmsp_pkg::QUERY_HIGH_RESET;
         query_len_ff  <= wmsp_pkg::QUERY_LEN_RESET;
      end else begin
         query_low_ff  <= query_low_in;
         query_high_ff <= query_high_in;
         query_len_ff  <= query_len_in;
      end
   end

   // A length of zero acts as one; anything past the window depth is clipped.
   always_comb begin
      priority if (query_len_ff == '0) begin
         eff_len = wmsp_pkg::LEN_W'(1);
      end else if (query_len_ff > wmsp_pkg::LEN_W'(MAX_QUERY)) begin
         eff_len = wmsp_pkg::LEN_W'(MAX_QUERY);
      end else begin
         eff_len = query_len_ff;
      end
   end

   assign query_chars = {query_high_ff, query_low_ff};

   // Front: window shift and parallel compare, one work item per full window.
   wmsp_front #(
      .MAX_QUERY (MAX_QUERY)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .query_chars (query_chars),
      .eff_len     (eff_len),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   // Two-entry queue so front and back stall independently.
   wmsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Back: saturating sum, history and peak test into the result register.
   wmsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp       (rsp)
   );

endmodule
